>>> rtl/hidkb_pkg.sv
package hidkb_pkg;

    localparam int KEY_SLOTS  = 6;
    localparam int SLOT_MAX   = 6;
    localparam int SLOT_LIMIT = (KEY_SLOTS > SLOT_MAX) ? SLOT_MAX :
                                ((KEY_SLOTS < 1) ? 1 : KEY_SLOTS);

    localparam logic [4:0] MOD_PREFIX    = 5'b11100;   // usages 0xE0..0xE7
    localparam logic [7:0] ROLLOVER_CODE = 8'h01;
    localparam logic [7:0] EMPTY_CODE    = 8'h00;
    localparam logic [2:0] ROLLOVER_COUNT = 3'(SLOT_MAX);

    typedef struct packed {
        logic       pressed;
        logic [7:0] usage;
        logic       last_key;
    } key_req_t;

    typedef struct packed {
        logic [7:0] modifiers;
        logic [7:0] key_slot_0;
        logic [7:0] key_slot_1;
        logic [7:0] key_slot_2;
        logic [7:0] key_slot_3;
        logic [7:0] key_slot_4;
        logic [7:0] key_slot_5;
        logic [2:0] key_count;
        logic       rollover;
    } report_t;

    typedef struct packed {
        logic       accept;
        logic       take;
        logic       last;
        logic [7:0] code;
    } slot_cmd_t;

    typedef struct packed {
        logic [SLOT_MAX-1:0][7:0] slots;
        logic [2:0]               count;
        logic                     rollover;
    } slot_view_t;

endpackage

>>> rtl/hidkb_key_if.sv
interface hidkb_key_if import hidkb_pkg::*;;
    logic     valid;
    logic     ready;
    key_req_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hidkb_report_if.sv
interface hidkb_report_if import hidkb_pkg::*;;
    logic    valid;
    logic    ready;
    report_t data;

    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

>>> rtl/hidkb_slot_table.sv
module hidkb_slot_table import hidkb_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  slot_cmd_t  cmd,
    output slot_view_t view
);

    logic [SLOT_MAX-1:0][7:0] slot_reg;
    logic [2:0]               fill_reg;
    logic [2:0]               fill_next;
    logic                     roll_reg;
    logic                     roll_next;
    logic                     full;
    logic                     seen;
    logic                     insert;

    assign full = (fill_reg >= 3'(SLOT_LIMIT));

    // duplicate check against the filled slots only
    always_comb
    begin
        seen = 1'b0;
        for (int j = 0; j < SLOT_MAX; j++)
        begin
            if ((3'(j) < fill_reg) && (slot_reg[j] == cmd.code))
            begin
                seen = 1'b1;
            end
        end
    end

    assign insert    = cmd.take && !full && !seen;
    assign roll_next = roll_reg || (cmd.take && full);
    assign fill_next = fill_reg + {2'b00, insert};

    // view of the table including the current request
    always_comb
    begin
        for (int k = 0; k < SLOT_MAX; k++)
        begin
            if (roll_next)
            begin
                view.slots[k] = ROLLOVER_CODE;
            end
            else if (3'(k) < fill_next)
            begin
                view.slots[k] = (insert && (3'(k) == fill_reg)) ? cmd.code : slot_reg[k];
            end
            else
            begin
                view.slots[k] = EMPTY_CODE;
            end
        end
        view.count    = roll_next ? ROLLOVER_COUNT : fill_next;
        view.rollover = roll_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= 3'd0;
            roll_reg <= 1'b0;
        end
        else if (cmd.accept)
        begin
            if (cmd.last)
            begin
                fill_reg <= 3'd0;
                roll_reg <= 1'b0;
            end
            else
            begin
                fill_reg <= fill_next;
                roll_reg <= roll_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept && insert)
        begin
            slot_reg[fill_reg] <= cmd.code;
        end
    end

`ifndef NO_ASSERTIONS
    a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
        fill_reg <= 3'(SLOT_LIMIT))
        else $error("slot fill beyond limit");

    a_scan_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.accept && cmd.last |=> (fill_reg == 3'd0) && !roll_reg)
        else $error("slot table not cleared after last key");

    a_no_insert_full: assert property (@(posedge clk) disable iff (!rst_n)
        full |-> !insert)
        else $error("insert into full slot table");
`endif

endmodule

>>> rtl/hid_boot_keyboard_report_builder_top.sv
// Boot keyboard report builder, six-key rollover. One key request is taken per clock:
// the modifier check and the six duplicate compares against the slot table finish in
// the cycle of the request, so the sustained rate is one key per cycle. The request
// flagged last_key loads the report into an output register, where it shows in the next
// cycle. While that report waits for the receiver no key request is taken;
// a report taken in the same cycle frees the register, so a stream with a ready
// receiver never stalls. The last key itself counts toward the report, after which
// the scan state starts empty.
module hid_boot_keyboard_report_builder_top import hidkb_pkg::*;
(
    input  logic           clk,
    input  logic           rst_n,
    hidkb_key_if.sink      key_in,
    hidkb_report_if.source report_out
);

    logic       accept;
    logic       is_mod;
    logic [7:0] mod_reg;
    logic [7:0] mod_next;
    slot_cmd_t  slot_cmd;
    slot_view_t slot_view;
    logic       out_valid_reg;
    report_t    out_data_reg;
    report_t    report_next;

    assign key_in.ready = !out_valid_reg || report_out.ready;
    assign accept       = key_in.valid && key_in.ready;

    assign is_mod   = (key_in.data.usage[7:3] == MOD_PREFIX);
    assign mod_next = (key_in.data.pressed && is_mod)
                      ? (mod_reg | (8'd1 << key_in.data.usage[2:0])) : mod_reg;

    assign slot_cmd.accept = accept;
    assign slot_cmd.take   = key_in.data.pressed && !is_mod
                             && (key_in.data.usage != EMPTY_CODE);
    assign slot_cmd.last   = key_in.data.last_key;
    assign slot_cmd.code   = key_in.data.usage;

    hidkb_slot_table u_slots (
        .clk   (clk),
        .rst_n (rst_n),
        .cmd   (slot_cmd),
        .view  (slot_view)
    );

    always_comb
    begin
        report_next.modifiers  = mod_next;
        report_next.key_slot_0 = slot_view.slots[0];
        report_next.key_slot_1 = slot_view.slots[1];
        report_next.key_slot_2 = slot_view.slots[2];
        report_next.key_slot_3 = slot_view.slots[3];
        report_next.key_slot_4 = slot_view.slots[4];
        report_next.key_slot_5 = slot_view.slots[5];
        report_next.key_count  = slot_view.count;
        report_next.rollover   = slot_view.rollover;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mod_reg       <= 8'd0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                mod_reg <= key_in.data.last_key ? 8'd0 : mod_next;
            end
            if (accept && key_in.data.last_key)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (report_out.ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept && key_in.data.last_key)
        begin
            out_data_reg <= report_next;
        end
    end

    assign report_out.valid = out_valid_reg;
    assign report_out.data  = out_data_reg;

`ifndef NO_ASSERTIONS
    a_last_gives_report: assert property (@(posedge clk) disable iff (!rst_n)
        accept && key_in.data.last_key |=> out_valid_reg)
        else $error("last key request did not produce a report");

    a_mod_clear: assert property (@(posedge clk) disable iff (!rst_n)
        accept && key_in.data.last_key |=> (mod_reg == 8'd0))
        else $error("modifiers not cleared after report");

    a_rollover_form: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && out_data_reg.rollover |->
            (out_data_reg.key_count == ROLLOVER_COUNT)
            && (out_data_reg.key_slot_0 == ROLLOVER_CODE)
            && (out_data_reg.key_slot_5 == ROLLOVER_CODE))
        else $error("malformed rollover report");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_data_reg.rollover |->
            (out_data_reg.key_count <= 3'(SLOT_LIMIT)))
        else $error("key count beyond slot limit");
`endif

endmodule

>>> test/hid_boot_keyboard_report_builder_top_tb.sv
`timescale 1ns / 1ps

module hid_boot_keyboard_report_builder_top_tb;
    import hidkb_pkg::*;

    localparam int HOLD_CYCLES = 200;
    localparam int QUIET_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 20;

    logic clk;
    logic rst_n;

    hidkb_key_if    key_bus ();
    hidkb_report_if report_bus ();

    hid_boot_keyboard_report_builder_top u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .key_in     (key_bus),
        .report_out (report_bus)
    );

    // scan state as the block should hold it
    logic [7:0] mod_bits;
    logic [7:0] slot_codes [SLOT_MAX];
    int         slots_used;
    bit         overflowed;

    report_t    pending_reports [$];
    int         fail_count;
    int         src_idle_pct;
    int         sink_stall_pct;
    int         hold_asked;
    int         hold_served;
    int         quiet_cycles;

    initial clk = 1'b0;
    always #10 clk = ~clk;

    task automatic report_mismatch(input string what);
        $display("[%0t] mismatch: %s", $realtime, what);
        fail_count++;
    endtask

    task automatic check_field(input string name, input logic [7:0] got,
                               input logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("%s got %h expected %h", name, got, want));
    endtask

    // Fold one accepted key request into the scan; a last key queues the report.
    function automatic void fold_key(input key_req_t req);
        report_t    rpt;
        logic [7:0] outs [SLOT_MAX];
        bit         dup;

        if (req.pressed && req.usage != EMPTY_CODE)
        begin
            if (req.usage[7:3] == MOD_PREFIX)
            begin
                mod_bits[req.usage[2:0]] = 1'b1;
            end
            else if (slots_used >= SLOT_LIMIT)
            begin
                // any new key when full trips rollover, duplicates too
                overflowed = 1'b1;
            end
            else
            begin
                dup = 1'b0;
                for (int j = 0; j < slots_used; j++)
                    if (slot_codes[j] == req.usage)
                        dup = 1'b1;
                if (!dup)
                begin
                    slot_codes[slots_used] = req.usage;
                    slots_used++;
                end
            end
        end

        if (req.last_key)
        begin
            for (int k = 0; k < SLOT_MAX; k++)
                outs[k] = overflowed ? ROLLOVER_CODE :
                          (k < slots_used) ? slot_codes[k] : EMPTY_CODE;
            rpt.modifiers  = mod_bits;
            rpt.key_slot_0 = outs[0];
            rpt.key_slot_1 = outs[1];
            rpt.key_slot_2 = outs[2];
            rpt.key_slot_3 = outs[3];
            rpt.key_slot_4 = outs[4];
            rpt.key_slot_5 = outs[5];
            rpt.key_count  = overflowed ? ROLLOVER_COUNT : 3'(slots_used);
            rpt.rollover   = overflowed;
            pending_reports.push_back(rpt);
            mod_bits   = '0;
            slots_used = 0;
            overflowed = 1'b0;
        end
    endfunction

    // Offer one key request; returns at the edge where it is accepted.
    task automatic send_key(input bit pressed, input logic [7:0] usage, input bit last);
        key_req_t req;

        req.pressed  = pressed;
        req.usage    = usage;
        req.last_key = last;
        while ($urandom_range(99) < src_idle_pct)
        begin
            key_bus.valid <= 1'b0;
            @(posedge clk);
        end
        key_bus.valid <= 1'b1;
        key_bus.data  <= req;
        do
            @(posedge clk);
        while (!key_bus.ready);
        fold_key(req);
    endtask

    function automatic logic [7:0] pick_usage();
        int roll;

        roll = $urandom_range(99);
        if (roll < 6)
            return EMPTY_CODE;
        else if (roll < 22)
            return {MOD_PREFIX, 3'($urandom_range(7))};
        else if (roll < 55)
            return 8'($urandom_range(4, 9));    // small pool, lots of duplicates
        else
            return 8'($urandom_range(1, 255));
    endfunction

    task automatic test_modifiers_and_ignored();
        send_key(1'b0, 8'h04, 1'b0);            // released key
        send_key(1'b1, EMPTY_CODE, 1'b0);       // unmapped key
        send_key(1'b1, 8'hE0, 1'b0);
        send_key(1'b1, 8'hE7, 1'b0);
        send_key(1'b1, 8'hE5, 1'b0);
        send_key(1'b1, 8'hDF, 1'b0);            // just below the modifier range
        send_key(1'b1, 8'hE8, 1'b0);            // just above it
        send_key(1'b0, 8'hFF, 1'b1);            // released last key still emits
        send_key(1'b0, EMPTY_CODE, 1'b1);       // empty scan
    endtask

    task automatic test_slots_and_rollover();
        send_key(1'b1, 8'h01, 1'b0);
        send_key(1'b1, 8'hFF, 1'b0);
        send_key(1'b1, 8'h04, 1'b0);
        send_key(1'b1, 8'h04, 1'b0);
        send_key(1'b1, 8'h10, 1'b0);
        send_key(1'b1, 8'h20, 1'b0);
        send_key(1'b1, 8'h80, 1'b0);
        send_key(1'b1, 8'h04, 1'b0);            // duplicate with slots full
        send_key(1'b1, 8'hE2, 1'b1);
        send_key(1'b1, 8'h3A, 1'b0);
        send_key(1'b1, 8'h3A, 1'b0);
        send_key(1'b1, 8'h3B, 1'b0);
        send_key(1'b1, 8'h3C, 1'b0);
        send_key(1'b1, 8'h3D, 1'b0);
        send_key(1'b1, 8'h3E, 1'b0);
        send_key(1'b1, 8'h3F, 1'b1);            // sixth key on the last request
    endtask

    task automatic test_random_scans(input int idle_pct, input int stall_pct,
                                     input int key_target);
        int         counted;
        int         scan_len;
        bit         pressed;
        logic [7:0] usage;

        src_idle_pct   = idle_pct;
        sink_stall_pct = stall_pct;
        counted = 0;
        while (counted < key_target)
        begin
            scan_len = $urandom_range(99) < 80 ? $urandom_range(0, 8) :
                                                 $urandom_range(9, 14);
            for (int i = 0; i <= scan_len; i++)
            begin
                pressed = $urandom_range(99) < 90;
                usage   = pick_usage();
                counted++;
                send_key(pressed, usage, i == scan_len);
            end
        end
    endtask

    // Receiver holds off while short scans keep coming, so the input backs up.
    task automatic test_receiver_hold();
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_asked++;
        for (int s = 0; s < 6; s++)
        begin
            send_key(1'b1, 8'($urandom_range(1, 255)), 1'b0);
            send_key(1'b1, 8'($urandom_range(1, 255)), 1'b1);
        end
    endtask

    // report receiver
    initial
    begin
        report_bus.ready = 1'b0;
        hold_served = 0;
        forever
        begin
            @(posedge clk);
            if (hold_asked != hold_served)
            begin
                hold_served = hold_asked;
                report_bus.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            report_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        report_t want;

        if (rst_n && report_bus.valid && report_bus.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                report_mismatch("report with none pending");
            end
            else
            begin
                want = pending_reports.pop_front();
                check_field("modifiers", report_bus.data.modifiers, want.modifiers);
                check_field("key_slot_0", report_bus.data.key_slot_0, want.key_slot_0);
                check_field("key_slot_1", report_bus.data.key_slot_1, want.key_slot_1);
                check_field("key_slot_2", report_bus.data.key_slot_2, want.key_slot_2);
                check_field("key_slot_3", report_bus.data.key_slot_3, want.key_slot_3);
                check_field("key_slot_4", report_bus.data.key_slot_4, want.key_slot_4);
                check_field("key_slot_5", report_bus.data.key_slot_5, want.key_slot_5);
                check_field("key_count", 8'(report_bus.data.key_count), 8'(want.key_count));
                check_field("rollover", 8'(report_bus.data.rollover), 8'(want.rollover));
            end
        end
    end

    // watchdog: cycles with no request moving on either side
    always @(posedge clk)
    begin
        if (!rst_n || (key_bus.valid && key_bus.ready) ||
            (report_bus.valid && report_bus.ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("FAILURE");
            $finish;
        end
    end

    initial
    begin
        rst_n          = 1'b0;
        key_bus.valid  = 1'b0;
        key_bus.data   = '0;
        mod_bits       = '0;
        slots_used     = 0;
        overflowed     = 1'b0;
        fail_count     = 0;
        src_idle_pct   = 0;
        sink_stall_pct = 0;
        hold_asked     = 0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_modifiers_and_ignored();
        test_slots_and_rollover();
        test_random_scans(0, 0, 140);
        test_random_scans(71, 0, 140);
        test_random_scans(0, 71, 140);
        test_random_scans(28, 28, 140);
        test_receiver_hold();
        key_bus.valid <= 1'b0;

        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (pending_reports.size() != 0)
            report_mismatch($sformatf("%0d reports never arrived", pending_reports.size()));

        if (fail_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
